@@ hdl/door_swing_decay_detector_top_defines.svh @@
// ----------------------------------------------------------------------------
// Door swing decay detector assertion macros
// Shared concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DOOR_SWING_DECAY_DETECTOR_TOP_DEFINES_SVH
`define DOOR_SWING_DECAY_DETECTOR_TOP_DEFINES_SVH

// Condition holds at every edge out of reset.
`define DSD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("dsd: invariant violated");

// Antecedent implies consequent in the same cycle.
`define DSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsd: implication violated");

`endif

@@ hdl/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Door swing decay detector package
// Widths, register indexes, status and extreme-kind codes.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam int COUNT_WIDTH = 16;  // swing counters
  localparam int RATE_WIDTH  = 20;  // gyro rate, 1/256 deg/s

  localparam int PITCH_W  = 16;
  localparam int ANGLE_W  = 15;
  localparam int FACTOR_W = 9;
  localparam int THR_W    = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ANGLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_ANGLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_THRESHOLD = 3'd3;

  localparam logic [ANGLE_W-1:0]  OPEN_ANGLE_RST      = 15'd384;
  localparam logic [ANGLE_W-1:0]  CLOSE_ANGLE_RST     = 15'd64;
  localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST    = 9'd128;
  localparam logic [THR_W-1:0]    SWING_THRESHOLD_RST = 19'd32;

  typedef enum logic [1:0] {
    ST_NOT_READY = 2'd0,
    ST_DETECTING = 2'd1,
    ST_OPEN      = 2'd2,
    ST_CLOSED    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PEAK   = 2'd1,
    KIND_TROUGH = 2'd2
  } kind_e;

endpackage

@@ hdl/door_swing_decay_detector_top.sv @@
// ----------------------------------------------------------------------------
// Door swing decay detector
// Tracks peaks and troughs of the door's x rate and reports open / closed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one fused IMU word per transfer,
//   taken at an edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i): one status word per input
//   word, in order: door_state_o, swings_seen_o, decaying_swings_o.
//   Config channel (cfg_valid_i / cfg_ready_o): register index and data;
//   always ready. Write only while the block is idle.
//   Path: a word taken lands in the input register, is evaluated and
//   loaded into the result register once that register is free;
//   out_valid_o is high after that load. Throughput: one word per cycle
//   while the output is not stalled, set by the single evaluate step (slope
//   compare, counter update, one 16x9 multiply and compare) between the input and result registers.
//   Stall: a stalled result holds; the input register keeps filling while
//   the result register drains, and in_stall_o rises only when both are full.
//   Reset: registers to defaults, counters zero, status held as detecting.
// ----------------------------------------------------------------------------
`include "door_swing_decay_detector_top_defines.svh"

module door_swing_decay_detector_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // config write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dsd_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [dsd_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    fusion_ready_i,
  input  logic signed [dsd_pkg::PITCH_W-1:0]      pitch_angle_i,
  input  logic signed [dsd_pkg::RATE_WIDTH-1:0]   rate_x_i,
  input  logic                                    gyro_moving_i,
  input  logic                                    accel_moving_i,
  // output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [1:0]                              door_state_o,
  output logic [dsd_pkg::COUNT_WIDTH-1:0]         swings_seen_o,
  output logic [dsd_pkg::COUNT_WIDTH-1:0]         decaying_swings_o
);
  import dsd_pkg::*;

  // signed compare width wide enough for rate and negated threshold
  localparam int CMP_W  = ((RATE_WIDTH > THR_W) ? RATE_WIDTH : THR_W) + 2;
  localparam int PROD_W = COUNT_WIDTH + FACTOR_W;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [ANGLE_W-1:0]  open_angle_q, close_angle_q;
  logic [FACTOR_W-1:0] decay_factor_q;
  logic [THR_W-1:0]    swing_threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_angle_q      <= OPEN_ANGLE_RST;
      close_angle_q     <= CLOSE_ANGLE_RST;
      decay_factor_q    <= DECAY_FACTOR_RST;
      swing_threshold_q <= SWING_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OPEN_ANGLE:      open_angle_q      <= cfg_data_i[ANGLE_W-1:0];
        CFG_CLOSE_ANGLE:     close_angle_q     <= cfg_data_i[ANGLE_W-1:0];
        CFG_DECAY_FACTOR:    decay_factor_q    <= cfg_data_i[FACTOR_W-1:0];
        CFG_SWING_THRESHOLD: swing_threshold_q <= cfg_data_i[THR_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register -> result register
  // --------------------------------------------------------------------------
  logic s0_valid_q, out_valid_q;
  logic s0_fire, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s0_fire    = s0_valid_q && out_free;
  assign in_stall_o = s0_valid_q && !out_free;
  assign out_valid_o = out_valid_q;

  logic                          s0_ready_q, s0_gmov_q, s0_amov_q;
  logic signed [PITCH_W-1:0]     s0_pitch_q;
  logic signed [RATE_WIDTH-1:0]  s0_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) s0_valid_q <= in_valid_i;
      if (out_free)    out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s0_ready_q <= fusion_ready_i;
      s0_pitch_q <= pitch_angle_i;
      s0_rate_q  <= rate_x_i;
      s0_gmov_q  <= gyro_moving_i;
      s0_amov_q  <= accel_moving_i;
    end
  end

  // --------------------------------------------------------------------------
  // Tracker state
  // --------------------------------------------------------------------------
  logic signed [RATE_WIDTH-1:0] prev_rate_q, prev_rate_d;
  logic                         rising_now_q, rising_now_d;
  logic                         rising_before_q, rising_before_d;
  logic                         primed_q, primed_d;
  logic [COUNT_WIDTH-1:0]       swing_total_q, swing_total_d;
  logic [COUNT_WIDTH-1:0]       decay_total_q, decay_total_d;
  kind_e                        last_kind_q, last_kind_d;
  kind_e                        older_kind_q, older_kind_d;
  logic [RATE_WIDTH-1:0]        last_extreme_q, last_extreme_d;
  logic [RATE_WIDTH-1:0]        older_extreme_q, older_extreme_d;
  status_e                      held_status_q, held_status_d;
  status_e                      status;

  // evaluate-step intermediates
  logic [PITCH_W-1:0]           pitch_mag;
  logic signed [CMP_W-1:0]      prev_ext, thr_ext, neg_thr;
  logic                         rn, peak_hit, trough_hit;
  kind_e                        kind;
  logic [RATE_WIDTH-1:0]        mag;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W-9:0]            need;

  assign pitch_mag = s0_pitch_q[PITCH_W-1] ? $unsigned(-s0_pitch_q) : $unsigned(s0_pitch_q);
  assign prev_ext  = CMP_W'(prev_rate_q);
  assign thr_ext   = $signed(CMP_W'(swing_threshold_q));
  assign neg_thr   = -thr_ext;

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  always_comb begin
    prev_rate_d     = s0_rate_q;
    rising_now_d    = rising_now_q;
    rising_before_d = rising_before_q;
    primed_d        = primed_q;
    swing_total_d   = swing_total_q;
    decay_total_d   = decay_total_q;
    last_kind_d     = last_kind_q;
    older_kind_d    = older_kind_q;
    last_extreme_d  = last_extreme_q;
    older_extreme_d = older_extreme_q;
    held_status_d   = held_status_q;
    status          = ST_NOT_READY;
    rn         = rising_now_q;
    peak_hit   = 1'b0;
    trough_hit = 1'b0;
    kind       = KIND_NONE;
    mag        = '0;
    prod       = '0;
    need       = '0;

    if (s0_ready_q) begin
      if (pitch_mag >= {1'b0, open_angle_q}) begin
        // door swung open: drop all tracking, keep slope bits
        primed_d        = 1'b0;
        swing_total_d   = '0;
        decay_total_d   = '0;
        last_kind_d     = KIND_NONE;
        older_kind_d    = KIND_NONE;
        last_extreme_d  = '0;
        older_extreme_d = '0;
        status          = ST_OPEN;
      end else begin
        if (prev_rate_q < s0_rate_q)      rn = 1'b1;
        else if (prev_rate_q > s0_rate_q) rn = 1'b0;

        if (primed_q) begin
          peak_hit   = !rn && rising_before_q && (prev_ext > thr_ext);
          trough_hit = rn && !rising_before_q && (prev_ext <= neg_thr);
          if (peak_hit || trough_hit) begin
            kind = peak_hit ? KIND_PEAK : KIND_TROUGH;
            mag  = peak_hit ? $unsigned(prev_rate_q) : $unsigned(-prev_rate_q);
            if (last_kind_q == kind) begin
              // repeated extreme: keep the larger one
              if (mag > last_extreme_q) last_extreme_d = mag;
            end else begin
              if (last_kind_q != KIND_NONE) begin
                if (older_kind_q != KIND_NONE) begin
                  if (last_extreme_q <= older_extreme_q) decay_total_d = sat_inc(decay_total_q);
                  swing_total_d = sat_inc(swing_total_q);
                end
                older_kind_d    = last_kind_q;
                older_extreme_d = last_extreme_q;
              end
              last_kind_d    = kind;
              last_extreme_d = mag;
            end
          end
          if (!s0_gmov_q && !s0_amov_q) begin
            prod = PROD_W'(swing_total_d) * PROD_W'(decay_factor_q);
            need = prod[PROD_W-1:8];
            if ((PROD_W-8)'(decay_total_d) >= need && pitch_mag < {1'b0, close_angle_q})
              held_status_d = ST_CLOSED;
            else
              held_status_d = ST_OPEN;
          end
        end else begin
          primed_d      = 1'b1;
          held_status_d = ST_DETECTING;
        end
        rising_now_d    = rn;
        rising_before_d = rn;
        status          = held_status_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rate_q     <= '0;
      rising_now_q    <= 1'b0;
      rising_before_q <= 1'b0;
      primed_q        <= 1'b0;
      swing_total_q   <= '0;
      decay_total_q   <= '0;
      last_kind_q     <= KIND_NONE;
      older_kind_q    <= KIND_NONE;
      last_extreme_q  <= '0;
      older_extreme_q <= '0;
      held_status_q   <= ST_DETECTING;
    end else if (s0_fire) begin
      prev_rate_q     <= prev_rate_d;
      rising_now_q    <= rising_now_d;
      rising_before_q <= rising_before_d;
      primed_q        <= primed_d;
      swing_total_q   <= swing_total_d;
      decay_total_q   <= decay_total_d;
      last_kind_q     <= last_kind_d;
      older_kind_q    <= older_kind_d;
      last_extreme_q  <= last_extreme_d;
      older_extreme_q <= older_extreme_d;
      held_status_q   <= held_status_d;
    end
  end

  // result register (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      door_state_o      <= status;
      swings_seen_o     <= swing_total_d;
      decaying_swings_o <= decay_total_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DSD_ASSERT_ALWAYS(a_decay_le_swing, decay_total_q <= swing_total_q)
  `DSD_ASSERT_IMPL(a_unprimed_no_swings, !primed_q, swing_total_q == '0)
  `DSD_ASSERT_IMPL(a_older_needs_last, last_kind_q == KIND_NONE, older_kind_q == KIND_NONE)
  `DSD_ASSERT_IMPL(a_no_needless_stall, !out_valid_q || !out_stall_i, !in_stall_o)

endmodule
